[sv/psit_pkg.sv]
// ----------------------------------------------------------------------------
// psit_pkg
// Shared widths, codes and controller/datapath interface types for the
// packed slot index table.
// ----------------------------------------------------------------------------
package psit_pkg;

  localparam int OP_W         = 2;
  localparam int ID_W         = 6;
  localparam int POS_W        = 6;
  localparam int CNT_OUT_W    = 7;
  localparam int ST_W         = 2;
  localparam int CAPACITY_DEF = 64;

  // Free-id scan examines one chunk of the live bitmap per cycle.
  localparam int CHK_W  = 16;
  localparam int CHK_LG = 4;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_LIVE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN,
    S_SCAN
  } psit_state_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_ALLOC,
    EM_FULL,
    EM_NOTLIVE,
    EM_DELETE,
    EM_LOOKUP
  } psit_emit_t;

  typedef struct packed {
    logic       accept;
    logic       alloc_wr;
    logic       del_wr;
    logic       scan_start;
    logic       scan_step;
    psit_emit_t emit;
  } psit_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_delete;
    logic full;
    logic live;
    logic scan_done;
  } psit_sts_t;

endpackage

[sv/psit_ctrl.sv]
// ----------------------------------------------------------------------------
// psit_ctrl
// Sequencer for the packed slot index table: accepts a word, steps it
// through decode, map update and the free-id scan.
// ----------------------------------------------------------------------------
module psit_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  psit_pkg::psit_sts_t sts,
  output psit_pkg::psit_cmd_t cmd
);
  import psit_pkg::*;

  psit_state_t state_r;
  psit_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.is_alloc) begin
          state_nxt = sts.full ? S_IDLE : S_SCAN;
        end else begin
          state_nxt = sts.live ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        state_nxt = start ? S_EXEC : S_IDLE;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = start ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      S_EXEC: begin
        if (sts.is_alloc) begin
          if (sts.full) begin
            cmd.emit = EM_FULL;
          end else begin
            cmd.alloc_wr   = 1'b1;
            cmd.scan_start = 1'b1;
            cmd.emit       = EM_ALLOC;
          end
        end else if (!sts.live) begin
          cmd.emit = EM_NOTLIVE;
        end
      end
      S_FIN: begin
        busy       = 1'b0;
        cmd.accept = start;
        if (sts.is_delete) begin
          cmd.del_wr = 1'b1;
          cmd.emit   = EM_DELETE;
        end else begin
          cmd.emit = EM_LOOKUP;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          busy       = 1'b0;
          cmd.accept = start;
        end
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

[sv/psit_datapath.sv]
// ----------------------------------------------------------------------------
// psit_datapath
// Live bitmap, id/position maps, row count, lowest-free-id tracker and the
// registered result word.
// ----------------------------------------------------------------------------
module psit_datapath #(
  parameter int CAPACITY = psit_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [psit_pkg::OP_W-1:0]      in_opcode,
  input  logic [psit_pkg::ID_W-1:0]      in_row_id,
  input  psit_pkg::psit_cmd_t            cmd,
  output psit_pkg::psit_sts_t            sts,
  output logic                           out_valid,
  output logic [psit_pkg::ID_W-1:0]      out_result_id,
  output logic [psit_pkg::POS_W-1:0]     out_row_position,
  output logic [psit_pkg::CNT_OUT_W-1:0] out_live_count,
  output logic [psit_pkg::ST_W-1:0]      out_status
);
  import psit_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;
  localparam int NCH   = (CAPACITY + CHK_W - 1) / CHK_W;
  localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PAD_W = NCH * CHK_W;

  logic [OP_W-1:0]      op_r;
  logic [ID_W-1:0]      rid_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     free_r;
  logic [CAPACITY-1:0]  live_r;
  logic [CH_W-1:0]      scan_ch_r;
  logic [IDX_W-1:0]     freed_r;
  logic [IDX_W-1:0]     last_id_r;

  logic [IDX_W-1:0]     i2p_mem [CAPACITY];
  logic [IDX_W-1:0]     p2i_mem [CAPACITY];

  logic                 out_valid_r;
  logic [ID_W-1:0]      res_id_r;
  logic [POS_W-1:0]     res_pos_r;
  logic [CNT_OUT_W-1:0] res_cnt_r;
  logic [ST_W-1:0]      res_st_r;

  logic [CMP_W-1:0]     rid_wide;
  logic [IDX_W-1:0]     rid_idx;
  logic                 in_range;
  logic [IDX_W-1:0]     alloc_id;
  logic [IDX_W-1:0]     alloc_pos;
  logic [IDX_W-1:0]     last_pos;
  logic [PAD_W-1:0]     padded;
  logic [CHK_W-1:0]     free_bits;
  logic [CHK_LG-1:0]    pe_idx;
  logic                 found;
  logic                 last_chunk;
  logic [CNT_W-1:0]     found_id;

  logic [ID_W-1:0]      res_id_nxt;
  logic [POS_W-1:0]     res_pos_nxt;
  logic [CNT_OUT_W-1:0] res_cnt_nxt;
  logic [ST_W-1:0]      res_st_nxt;

  assign rid_wide  = CMP_W'(rid_r);
  assign rid_idx   = rid_wide[IDX_W-1:0];
  assign in_range  = rid_wide < CMP_W'(CAPACITY);
  assign alloc_id  = free_r[IDX_W-1:0];
  assign alloc_pos = count_r[IDX_W-1:0];
  assign last_pos  = IDX_W'(count_r - 1'b1);

  assign sts.is_alloc  = (op_r == OP_ALLOC);
  assign sts.is_delete = (op_r == OP_DELETE);
  assign sts.full      = (count_r == CNT_W'(CAPACITY));
  assign sts.live      = in_range && live_r[rid_idx];
  assign sts.scan_done = found || last_chunk;

  // Pad beyond capacity with ones so the scan never hands out those ids.
  always_comb begin
    padded                 = '1;
    padded[CAPACITY-1:0]   = live_r;
  end

  assign free_bits  = ~padded[scan_ch_r * CHK_W +: CHK_W];
  assign found      = |free_bits;
  assign last_chunk = (scan_ch_r == CH_W'(NCH - 1));
  assign found_id   = CNT_W'({scan_ch_r, pe_idx});

  always_comb begin
    pe_idx = '0;
    for (int i = CHK_W - 1; i >= 0; i--) begin
      if (free_bits[i]) pe_idx = CHK_LG'(i);
    end
  end

  always_comb begin
    res_id_nxt  = rid_r;
    res_pos_nxt = '0;
    res_cnt_nxt = CNT_OUT_W'(count_r);
    res_st_nxt  = ST_OK;
    case (cmd.emit)
      EM_ALLOC: begin
        res_id_nxt  = ID_W'(alloc_id);
        res_pos_nxt = POS_W'(alloc_pos);
        res_cnt_nxt = CNT_OUT_W'(count_r + 1'b1);
      end
      EM_FULL: begin
        res_id_nxt = '0;
        res_st_nxt = ST_FULL;
      end
      EM_NOTLIVE: res_st_nxt = ST_NOT_LIVE;
      EM_DELETE:  res_cnt_nxt = CNT_OUT_W'(count_r - 1'b1);
      EM_LOOKUP:  res_pos_nxt = POS_W'(freed_r);
      default:    res_st_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      free_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.emit != EM_NONE);
      if (cmd.alloc_wr) begin
        live_r[alloc_id] <= 1'b1;
        count_r          <= count_r + 1'b1;
      end
      if (cmd.del_wr) begin
        live_r[rid_idx] <= 1'b0;
        count_r         <= count_r - 1'b1;
        if (CNT_W'(rid_idx) < free_r) free_r <= CNT_W'(rid_idx);
      end
      if (cmd.scan_step && sts.scan_done) begin
        free_r <= found ? found_id : CNT_W'(CAPACITY);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_opcode;
      rid_r <= in_row_id;
    end
    freed_r   <= i2p_mem[rid_idx];
    last_id_r <= p2i_mem[last_pos];
    if (cmd.alloc_wr) begin
      i2p_mem[alloc_id]  <= alloc_pos;
      p2i_mem[alloc_pos] <= alloc_id;
    end
    if (cmd.del_wr) begin
      p2i_mem[freed_r]   <= last_id_r;
      i2p_mem[last_id_r] <= freed_r;
    end
    if (cmd.scan_start) scan_ch_r <= CH_W'(free_r >> CHK_LG);
    else if (cmd.scan_step) scan_ch_r <= scan_ch_r + 1'b1;
    if (cmd.emit != EM_NONE) begin
      res_id_r  <= res_id_nxt;
      res_pos_r <= res_pos_nxt;
      res_cnt_r <= res_cnt_nxt;
      res_st_r  <= res_st_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_id    = res_id_r;
  assign out_row_position = res_pos_r;
  assign out_live_count   = res_cnt_r;
  assign out_status       = res_st_r;

endmodule

[sv/packed_slot_index_table.sv]
// ----------------------------------------------------------------------------
// packed_slot_index_table
// Sparse-set slot map: allocate lowest free id, delete by id with
// swap-from-back, look up packed position; each command returns one word.
// ----------------------------------------------------------------------------
// Result: a rejected word or an allocate is emitted from the execute state;
//   delete and lookup from the finish state, after the registered map reads.
// Throughput: a word is taken only when idle or in a word's final state, so
//   words do not overlap; allocate adds the scan for the next free id,
//   walking the live bitmap 16 ids per cycle.
// Reset: synchronous; clears live bitmap, row count and free pointer at once.
//   Maps are left unwritten and need no clearing pass. No result stalls.
module packed_slot_index_table #(
  parameter int CAPACITY = psit_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [psit_pkg::OP_W-1:0]      in_opcode,
  input  logic [psit_pkg::ID_W-1:0]      in_row_id,
  output logic                           out_valid,
  output logic [psit_pkg::ID_W-1:0]      out_result_id,
  output logic [psit_pkg::POS_W-1:0]     out_row_position,
  output logic [psit_pkg::CNT_OUT_W-1:0] out_live_count,
  output logic [psit_pkg::ST_W-1:0]      out_status
);
  import psit_pkg::*;

  // Command and status between the sequencer and the datapath.
  psit_cmd_t cmd;
  psit_sts_t sts;

  // Sequencer: accept a word when idle or when the previous word is in its
  // final cycle, drive the map writes, and hold busy while scanning.
  psit_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath: live bitmap in flops, the two maps as memories with
  // registered reads, and the result register that parts us from the sink.
  psit_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_row_id        (in_row_id),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_result_id    (out_result_id),
    .out_row_position (out_row_position),
    .out_live_count   (out_live_count),
    .out_status       (out_status)
  );

endmodule

[sv/psit_checker.sv]
// ----------------------------------------------------------------------------
// psit_checker
// Port-level checks of the packed slot index table, bound to the top level.
// ----------------------------------------------------------------------------
module psit_checker #(
  parameter int CAPACITY = psit_pkg::CAPACITY_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [psit_pkg::OP_W-1:0]      in_opcode,
  input logic [psit_pkg::ID_W-1:0]      in_row_id,
  input logic                           out_valid,
  input logic [psit_pkg::ID_W-1:0]      out_result_id,
  input logic [psit_pkg::POS_W-1:0]     out_row_position,
  input logic [psit_pkg::CNT_OUT_W-1:0] out_live_count,
  input logic [psit_pkg::ST_W-1:0]      out_status
);
  import psit_pkg::*;

  // Reset leaves the block idle with no result word in flight.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy seen right after reset");

  // An accepted word always occupies the block for its decode cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting a word");

  // Table full is reported only with the count at capacity and zero fields.
  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_result_id == '0 && out_row_position == '0 &&
      out_live_count == CNT_OUT_W'(CAPACITY))
    else $error("full status with wrong fields");

  a_notlive_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOT_LIVE |-> out_row_position == '0)
    else $error("not-live status with nonzero position");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_status == ST_OK || out_status == ST_FULL || out_status == ST_NOT_LIVE))
    else $error("undefined status code");

endmodule

bind packed_slot_index_table psit_checker #(.CAPACITY(CAPACITY)) u_psit_checker (.*);
